/* design/azct_pkg.sv */
package azct_pkg;

    // Item codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Aux modes (code 3 behaves as plain)
    localparam logic [1:0] AUX_PLAIN = 2'd0;
    localparam logic [1:0] AUX_ESTOP = 2'd1;
    localparam logic [1:0] AUX_TONE  = 2'd2;

    // Register indexes, byte address 4*index
    localparam logic [2:0] REG_ZCD_ENABLE       = 3'd0;
    localparam logic [2:0] REG_FILTER_COEF      = 3'd1;
    localparam logic [2:0] REG_THRESHOLD_CENTER = 3'd2;
    localparam logic [2:0] REG_THRESHOLD_WIDTH  = 3'd3;
    localparam logic [2:0] REG_HOLDOFF_TICKS    = 3'd4;
    localparam logic [2:0] REG_TARGET_ONTIME    = 3'd5;
    localparam logic [2:0] REG_FORWARD_ENABLE   = 3'd6;
    localparam logic [2:0] REG_AUX_MODE         = 3'd7;

    localparam logic [6:0] COEF_FULL  = 7'd64;
    localparam logic [15:0] MIN_PULSE = 16'd3;

    // holdoff*100/133 as (holdoff*HOLDOFF_RECIP) >> HOLDOFF_SHIFT, exact for 16-bit holdoff
    localparam logic [23:0] HOLDOFF_RECIP = 24'd12614449;
    localparam int          HOLDOFF_SHIFT = 24;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] sample;
        logic               estop_ok;
    } in_word_t;

    typedef struct packed {
        logic signed [15:0] filtered;
        logic               polarity;
        logic               fired;
        logic [15:0]        pulse_len;
        logic               drive_main;
        logic               drive_aux;
        logic               forward_valid;
    } out_word_t;

    typedef struct packed {
        logic               zcd_enable;
        logic [6:0]         filter_coef;
        logic signed [15:0] threshold_center;
        logic [13:0]        threshold_width;
        logic [15:0]        holdoff_period;
        logic [15:0]        target_ontime;
        logic               forward_enable;
        logic [1:0]         aux_mode;
    } cfg_t;

endpackage

/* design/azct_item_if.sv */
interface azct_item_if import azct_pkg::*; ();
    logic     valid;
    logic     ready;
    in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/azct_result_if.sv */
interface azct_result_if import azct_pkg::*; ();
    logic      valid;
    logic      ready;
    out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* design/azct_core.sv */
module azct_core import azct_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_word_t  word,
    input  cfg_t      cfg,
    output out_word_t res
);

    logic signed [15:0] filter_value_reg, filter_value_next;
    logic               last_polarity_reg, last_polarity_next;
    logic [15:0]        peak_level_reg, peak_level_next;
    logic               armed_reg, armed_next;
    logic               pulse_active_reg, pulse_active_next;
    logic               timer_running_reg, timer_running_next;
    logic [15:0]        timer_count_reg, timer_count_next;
    logic [15:0]        timer_period_reg, timer_period_next;
    logic [1:0]         pin_state_reg, pin_state_next;

    logic [6:0]         coef_sat;
    logic [6:0]         coef_inv;
    logic signed [22:0] prod_old;
    logic signed [22:0] prod_new;
    logic signed [22:0] filt_sum;
    logic signed [15:0] filt_new;
    logic signed [17:0] filt_ext;
    logic signed [17:0] thr_hi;
    logic signed [17:0] thr_lo;
    logic               pol;
    logic [15:0]        mag;
    logic [15:0]        peak_new;
    logic [31:0]        len_prod;
    logic [15:0]        len_sat;
    logic               fired;
    logic [15:0]        plen;
    logic               fwd;

    // Sample datapath
    always_comb
    begin
        coef_sat = (cfg.filter_coef > COEF_FULL) ? COEF_FULL : cfg.filter_coef;
        coef_inv = COEF_FULL - coef_sat;
        prod_old = filter_value_reg * $signed({1'b0, coef_sat});
        prod_new = word.sample * $signed({1'b0, coef_inv});
        filt_sum = prod_old + prod_new;
        // floor shift; the weighted sum always fits back into 16 bits
        filt_new = filt_sum[21:6];
        filt_ext = {{2{filt_new[15]}}, filt_new};
        thr_hi   = {{2{cfg.threshold_center[15]}}, cfg.threshold_center}
                 + $signed({4'd0, cfg.threshold_width});
        thr_lo   = {{2{cfg.threshold_center[15]}}, cfg.threshold_center}
                 - $signed({4'd0, cfg.threshold_width});
        pol      = last_polarity_reg ? (filt_ext > thr_lo) : (filt_ext > thr_hi);
        mag      = word.sample[15] ? 16'(~word.sample + 16'sd1) : word.sample;
        peak_new = (mag > peak_level_reg) ? mag : peak_level_reg;
        len_prod = peak_new * cfg.target_ontime;
        len_sat  = len_prod[31] ? 16'hFFFF : len_prod[30:15];
    end

    always_comb
    begin
        filter_value_next  = filter_value_reg;
        last_polarity_next = last_polarity_reg;
        peak_level_next    = peak_level_reg;
        armed_next         = armed_reg;
        pulse_active_next  = pulse_active_reg;
        timer_running_next = timer_running_reg;
        timer_count_next   = timer_count_reg;
        timer_period_next  = timer_period_reg;
        pin_state_next     = pin_state_reg;
        fired              = 1'b0;
        plen               = 16'd0;
        fwd                = 1'b0;

        if (word.cmd == CMD_TICK)
        begin
            if (timer_running_reg)
            begin
                if (timer_count_reg >= timer_period_reg)
                begin
                    timer_count_next  = 16'd0;
                    pin_state_next[0] = 1'b0;
                    if (cfg.aux_mode == AUX_TONE)
                    begin
                        pin_state_next[1] = 1'b0;
                    end
                    if (pulse_active_reg)
                    begin
                        pulse_active_next = 1'b0;
                        timer_period_next = cfg.holdoff_period;
                    end
                    else
                    begin
                        armed_next         = 1'b1;
                        timer_running_next = 1'b0;
                    end
                end
                else
                begin
                    timer_count_next = timer_count_reg + 16'd1;
                end
            end
        end
        else if (cfg.zcd_enable)
        begin
            peak_level_next   = peak_new;
            filter_value_next = filt_new;
            pin_state_next[1] = pol;
            if (last_polarity_reg && !pol)
            begin
                plen = len_sat;
                if ((len_sat > MIN_PULSE) && armed_reg)
                begin
                    timer_period_next  = len_sat;
                    timer_count_next   = 16'd0;
                    armed_next         = 1'b0;
                    timer_running_next = 1'b1;
                    pulse_active_next  = 1'b1;
                    fired              = 1'b1;
                    if ((cfg.aux_mode != AUX_ESTOP) || word.estop_ok)
                    begin
                        pin_state_next[0] = 1'b1;
                        if (cfg.aux_mode == AUX_TONE)
                        begin
                            pin_state_next[1] = 1'b1;
                        end
                    end
                end
            end
            last_polarity_next = pol;
            fwd                = cfg.forward_enable;
        end
    end

    always_comb
    begin
        res.filtered      = filter_value_next;
        res.polarity      = last_polarity_next;
        res.fired         = fired;
        res.pulse_len     = plen;
        res.drive_main    = pin_state_next[0];
        res.drive_aux     = (cfg.aux_mode == AUX_TONE) ? pin_state_next[1] : 1'b0;
        res.forward_valid = fwd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_value_reg  <= '0;
            last_polarity_reg <= 1'b0;
            peak_level_reg    <= '0;
            armed_reg         <= 1'b1;
            pulse_active_reg  <= 1'b0;
            timer_running_reg <= 1'b0;
            timer_count_reg   <= '0;
            timer_period_reg  <= '0;
            pin_state_reg     <= '0;
        end
        else if (step)
        begin
            filter_value_reg  <= filter_value_next;
            last_polarity_reg <= last_polarity_next;
            peak_level_reg    <= peak_level_next;
            armed_reg         <= armed_next;
            pulse_active_reg  <= pulse_active_next;
            timer_running_reg <= timer_running_next;
            timer_count_reg   <= timer_count_next;
            timer_period_reg  <= timer_period_next;
            pin_state_reg     <= pin_state_next;
        end
    end

endmodule

/* design/audio_zero_cross_pulse_trigger.sv */
// Channel   Dir   Word        Fields
// item      in    in_word_t   cmd, sample, estop_ok
// result    out   out_word_t  filtered, polarity, fired, pulse_len,
//                             drive_main, drive_aux, forward_valid
// apb       in    32-bit      eight registers at byte address 4*index
//
// One word per cycle sustained while the result is taken; each word is held in the
// input register, then its result is registered in the result register.
// The path from input register to result register holds the filter
// multipliers and the peak * on-time multiply with its compare.
// rst_n clears the valid flags, configuration and core state at once; no clearing pass.
// A stalled result holds; the input register still takes one more word.
module audio_zero_cross_pulse_trigger import azct_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    azct_item_if.sink     item,
    azct_result_if.source result,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic               zcd_enable_reg;
    logic [6:0]         filter_coef_reg;
    logic signed [15:0] threshold_center_reg;
    logic [13:0]        threshold_width_reg;
    logic [15:0]        holdoff_ticks_reg;
    logic [15:0]        holdoff_period_reg;
    logic [15:0]        holdoff_period_next;
    logic [15:0]        target_ontime_reg;
    logic               forward_enable_reg;
    logic [1:0]         aux_mode_reg;

    logic               cfg_write;
    logic [2:0]         cfg_idx;
    logic [39:0]        holdoff_prod;
    cfg_t               cfg;

    logic               in_valid_reg;
    in_word_t           in_word_reg;
    logic               out_valid_reg;
    out_word_t          out_word_reg;
    logic               advance;
    out_word_t          core_res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[4:2];

    assign holdoff_prod        = pwdata[15:0] * HOLDOFF_RECIP;
    assign holdoff_period_next = holdoff_prod[HOLDOFF_SHIFT +: 16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zcd_enable_reg       <= 1'b0;
            filter_coef_reg      <= '0;
            threshold_center_reg <= '0;
            threshold_width_reg  <= '0;
            holdoff_ticks_reg    <= '0;
            holdoff_period_reg   <= '0;
            target_ontime_reg    <= '0;
            forward_enable_reg   <= 1'b0;
            aux_mode_reg         <= AUX_PLAIN;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_ZCD_ENABLE:       zcd_enable_reg       <= pwdata[0];
                REG_FILTER_COEF:      filter_coef_reg      <= pwdata[6:0];
                REG_THRESHOLD_CENTER: threshold_center_reg <= pwdata[15:0];
                REG_THRESHOLD_WIDTH:  threshold_width_reg  <= pwdata[13:0];
                REG_HOLDOFF_TICKS:
                begin
                    holdoff_ticks_reg  <= pwdata[15:0];
                    holdoff_period_reg <= holdoff_period_next;
                end
                REG_TARGET_ONTIME:    target_ontime_reg    <= pwdata[15:0];
                REG_FORWARD_ENABLE:   forward_enable_reg   <= pwdata[0];
                REG_AUX_MODE:         aux_mode_reg         <= pwdata[1:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ZCD_ENABLE:       prdata = {31'd0, zcd_enable_reg};
            REG_FILTER_COEF:      prdata = {25'd0, filter_coef_reg};
            REG_THRESHOLD_CENTER: prdata = {16'd0, threshold_center_reg};
            REG_THRESHOLD_WIDTH:  prdata = {18'd0, threshold_width_reg};
            REG_HOLDOFF_TICKS:    prdata = {16'd0, holdoff_ticks_reg};
            REG_TARGET_ONTIME:    prdata = {16'd0, target_ontime_reg};
            REG_FORWARD_ENABLE:   prdata = {31'd0, forward_enable_reg};
            REG_AUX_MODE:         prdata = {30'd0, aux_mode_reg};
            default:              prdata = 32'd0;
        endcase
    end

    always_comb
    begin
        cfg.zcd_enable       = zcd_enable_reg;
        cfg.filter_coef      = filter_coef_reg;
        cfg.threshold_center = threshold_center_reg;
        cfg.threshold_width  = threshold_width_reg;
        cfg.holdoff_period   = holdoff_period_reg;
        cfg.target_ontime    = target_ontime_reg;
        cfg.forward_enable   = forward_enable_reg;
        cfg.aux_mode         = aux_mode_reg;
    end

    // word moves on when the result register is free or being emptied
    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item.valid && item.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            in_word_reg <= item.data;
        end
    end

    azct_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .word  (in_word_reg),
        .cfg   (cfg),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg <= core_res;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_word_reg;

endmodule

/* design/azct_checker.sv */
module azct_checker import azct_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_data
);

    // a pulse only starts above the minimum length
    a_fired_len: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.fired) |-> (out_data.pulse_len > MIN_PULSE))
        else $error("pulse fired with length at or below minimum");

    // a length is only reported on a falling edge, so polarity is low
    a_len_falling: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (out_data.pulse_len != 16'd0)) |-> !out_data.polarity)
        else $error("pulse length reported without falling edge");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result word changed");

endmodule

bind audio_zero_cross_pulse_trigger azct_checker u_azct_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

/* tb/tb_audio_zero_cross_pulse_trigger.sv */
module tb_audio_zero_cross_pulse_trigger;
    import azct_pkg::*;

    localparam int PHASES      = 10;
    localparam int PHASE_WORDS = 150;
    localparam logic [1:0] AUX_SPARE = 2'd3;

    typedef struct {
        bit          is_reg;
        logic [2:0]  idx;
        logic [31:0] val;
        in_word_t    word;
        bit          typed;
        out_word_t   res;
    } plan_row_t;

    typedef struct {
        bit        typed;
        out_word_t res;
    } typed_res_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    azct_item_if   item_ch ();
    azct_result_if result_ch ();

    audio_zero_cross_pulse_trigger dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // register copies
    bit                 m_en;
    bit [6:0]           m_coef;
    logic signed [15:0] m_ctr;
    bit [13:0]          m_width;
    bit [15:0]          m_holdoff;
    bit [15:0]          m_ontime;
    bit                 m_fwd;
    bit [1:0]           m_aux;

    // block state
    logic signed [15:0] filt;
    bit                 last_pol;
    bit [15:0]          peak;
    bit                 armed;
    bit                 pulse_on;
    bit                 tmr_run;
    bit [15:0]          tmr_cnt;
    bit [15:0]          tmr_per;
    bit                 main_pin;
    bit                 aux_pin;

    out_word_t  pending_results[$];
    typed_res_t typed_q[$];
    plan_row_t  dir_plan[$];

    int idle_pct = 18;
    int errors   = 0;
    int words_in = 0;
    int checked  = 0;
    int pulses   = 0;
    int settings = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("[audio_zero_cross_pulse_trigger] ERROR");
        $finish;
    end

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            REG_ZCD_ENABLE:       m_en      = val[0];
            REG_FILTER_COEF:      m_coef    = val[6:0];
            REG_THRESHOLD_CENTER: m_ctr     = val[15:0];
            REG_THRESHOLD_WIDTH:  m_width   = val[13:0];
            REG_HOLDOFF_TICKS:    m_holdoff = val[15:0];
            REG_TARGET_ONTIME:    m_ontime  = val[15:0];
            REG_FORWARD_ENABLE:   m_fwd     = val[0];
            REG_AUX_MODE:         m_aux     = val[1:0];
            default: ;
        endcase
    endfunction

    function automatic out_word_t predict_zc_result(in_word_t w);
        out_word_t   r;
        int          s;
        int          mag;
        int          c;
        int          nf;
        int          hi;
        int          lo;
        int unsigned len;
        bit          pol;
        r = '0;
        if (w.cmd == CMD_TICK)
        begin
            if (tmr_run)
            begin
                if (tmr_cnt >= tmr_per)
                begin
                    tmr_cnt  = '0;
                    main_pin = 1'b0;
                    if (m_aux == AUX_TONE)
                        aux_pin = 1'b0;
                    if (pulse_on)
                    begin
                        // on-time over, holdoff follows
                        pulse_on = 1'b0;
                        tmr_per  = 16'((32'(m_holdoff) * 100) / 133);
                    end
                    else
                    begin
                        armed   = 1'b1;
                        tmr_run = 1'b0;
                    end
                end
                else
                begin
                    tmr_cnt = tmr_cnt + 16'd1;
                end
            end
        end
        else if (m_en)
        begin
            s   = $signed(w.sample);
            mag = (s < 0) ? -s : s;
            c   = (m_coef > COEF_FULL) ? int'(COEF_FULL) : int'(m_coef);
            nf  = (int'(filt) * c + s * (int'(COEF_FULL) - c)) >>> 6;
            filt = 16'(nf);
            if (mag > int'(peak))
                peak = 16'(mag);
            hi  = int'(m_ctr) + int'(m_width);
            lo  = int'(m_ctr) - int'(m_width);
            pol = last_pol ? (nf > lo) : (nf > hi);
            aux_pin = pol;
            if (last_pol && !pol)
            begin
                len = (32'(peak) * 32'(m_ontime)) >> 15;
                if (len > 32'hFFFF)
                    len = 32'hFFFF;
                r.pulse_len = 16'(len);
                if (len > MIN_PULSE && armed)
                begin
                    tmr_per  = 16'(len);
                    tmr_cnt  = '0;
                    armed    = 1'b0;
                    tmr_run  = 1'b1;
                    pulse_on = 1'b1;
                    r.fired  = 1'b1;
                    // estop gating: timers run, pins stay low
                    if (m_aux != AUX_ESTOP || w.estop_ok)
                    begin
                        main_pin = 1'b1;
                        if (m_aux == AUX_TONE)
                            aux_pin = 1'b1;
                    end
                end
            end
            last_pol = pol;
            r.forward_valid = m_fwd;
        end
        r.filtered   = filt;
        r.polarity   = last_pol;
        r.drive_main = main_pin;
        r.drive_aux  = (m_aux == AUX_TONE) ? aux_pin : 1'b0;
        return r;
    endfunction

    function automatic out_word_t mk_res(int f, bit pol, bit fired, int len, bit dm, bit da,
                                         bit fv);
        out_word_t r;
        r.filtered      = 16'(f);
        r.polarity      = pol;
        r.fired         = fired;
        r.pulse_len     = 16'(len);
        r.drive_main    = dm;
        r.drive_aux     = da;
        r.forward_valid = fv;
        return r;
    endfunction

    function automatic void plan_reg(logic [2:0] idx, logic [31:0] val);
        plan_row_t row;
        row.is_reg = 1'b1;
        row.idx    = idx;
        row.val    = val;
        row.word   = '0;
        row.typed  = 1'b0;
        row.res    = '0;
        dir_plan.push_back(row);
    endfunction

    function automatic void plan_word(logic cmd, logic [15:0] smp, logic ok, bit typed = 1'b0,
                                      out_word_t res = '0);
        plan_row_t row;
        row.is_reg        = 1'b0;
        row.idx           = '0;
        row.val           = '0;
        row.word.cmd      = cmd;
        row.word.sample   = smp;
        row.word.estop_ok = ok;
        row.typed         = typed;
        row.res           = res;
        dir_plan.push_back(row);
    endfunction

    function automatic void check_field(string nm, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s expected %h got %h", $time, nm, want, got);
        end
    endfunction

    task automatic send_word(in_word_t w, bit typed, out_word_t res);
        typed_res_t t;
        t.typed = typed;
        t.res   = res;
        typed_q.push_back(t);
        while ($urandom_range(99) < idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= w;
        @(posedge clk);
        while (!item_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // drain everything in flight before touching a register
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic apb_write(logic [2:0] idx, logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        apply_reg(idx, val);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic program_regs(bit en, int coef, int ctr, int width, int holdoff, int ontime,
                                bit fwd, logic [1:0] aux);
        settle();
        apb_write(REG_ZCD_ENABLE, 32'(en));
        apb_write(REG_FILTER_COEF, 32'(coef));
        apb_write(REG_THRESHOLD_CENTER, {16'h0000, 16'(ctr)});
        apb_write(REG_THRESHOLD_WIDTH, 32'(width));
        apb_write(REG_HOLDOFF_TICKS, 32'(holdoff));
        apb_write(REG_TARGET_ONTIME, 32'(ontime));
        apb_write(REG_FORWARD_ENABLE, 32'(fwd));
        apb_write(REG_AUX_MODE, 32'(aux));
        settings++;
    endtask

    always @(negedge clk)
        result_ch.ready <= ($urandom_range(99) >= idle_pct);

    always @(posedge clk)
    begin
        typed_res_t t;
        out_word_t  p;
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            p = predict_zc_result(item_ch.data);
            t = typed_q.pop_front();
            if (p.fired)
                pulses++;
            pending_results.push_back(t.typed ? t.res : p);
            words_in++;
        end
    end

    always @(posedge clk)
    begin
        out_word_t e;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result word with nothing pending, expected none got %h", $time,
                         result_ch.data);
            end
            else
            begin
                e = pending_results.pop_front();
                checked++;
                check_field("filtered", e.filtered, result_ch.data.filtered);
                check_field("polarity", e.polarity, result_ch.data.polarity);
                check_field("fired", e.fired, result_ch.data.fired);
                check_field("pulse_len", e.pulse_len, result_ch.data.pulse_len);
                check_field("drive_main", e.drive_main, result_ch.data.drive_main);
                check_field("drive_aux", e.drive_aux, result_ch.data.drive_aux);
                check_field("forward_valid", e.forward_valid, result_ch.data.forward_valid);
            end
        end
    end

    initial
    begin
        in_word_t w;
        int       amp;
        int       hp;
        int       run;
        int       s;
        int       roll;
        bit       lvl;

        rst_n           = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        item_ch.valid   = 1'b0;
        item_ch.data    = '0;
        result_ch.ready = 1'b0;

        m_en = 1'b0;  m_coef = '0;  m_ctr = '0;  m_width = '0;
        m_holdoff = '0;  m_ontime = '0;  m_fwd = 1'b0;  m_aux = AUX_PLAIN;
        filt = '0;  last_pol = 1'b0;  peak = '0;  armed = 1'b1;  pulse_on = 1'b0;
        tmr_run = 1'b0;  tmr_cnt = '0;  tmr_per = '0;  main_pin = 1'b0;  aux_pin = 1'b0;

        // straight out of reset: disabled sample and idle tick report zeros
        plan_word(CMD_SAMPLE, 16'h7FFF, 1'b1, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0));
        plan_word(CMD_TICK, 16'h8000, 1'b1, 1'b1, mk_res(0, 0, 0, 0, 0, 0, 0));
        plan_reg(REG_ZCD_ENABLE, 1);
        plan_reg(REG_FILTER_COEF, 0);
        plan_reg(REG_THRESHOLD_CENTER, 0);
        plan_reg(REG_THRESHOLD_WIDTH, 100);
        plan_reg(REG_HOLDOFF_TICKS, 1);
        plan_reg(REG_TARGET_ONTIME, 4);
        plan_reg(REG_FORWARD_ENABLE, 1);
        plan_reg(REG_AUX_MODE, AUX_TONE);
        // coef 0 passes the sample straight through; full-scale swing fires length 4
        plan_word(CMD_SAMPLE, 16'h7FFF, 1'b1, 1'b1, mk_res(32767, 1, 0, 0, 0, 1, 1));
        plan_word(CMD_SAMPLE, 16'h8000, 1'b1, 1'b1, mk_res(-32768, 0, 1, 4, 1, 1, 1));
        // on-time, zero holdoff, re-arm
        repeat (6) plan_word(CMD_TICK, 16'h0000, 1'b1);
        plan_word(CMD_SAMPLE, 16'h7FFF, 1'b0);
        plan_reg(REG_AUX_MODE, AUX_ESTOP);
        plan_word(CMD_SAMPLE, 16'h8000, 1'b0);
        plan_word(CMD_TICK, 16'hFFFF, 1'b0);
        plan_word(CMD_TICK, 16'hFFFF, 1'b0);
        // coef above full scale, thresholds past the 16-bit range, spare aux code
        plan_reg(REG_FILTER_COEF, 127);
        plan_reg(REG_THRESHOLD_CENTER, 32'h0000_8000);
        plan_reg(REG_THRESHOLD_WIDTH, 16383);
        plan_reg(REG_AUX_MODE, AUX_SPARE);
        plan_reg(REG_FORWARD_ENABLE, 0);
        plan_word(CMD_SAMPLE, 16'h0000, 1'b1);
        plan_word(CMD_SAMPLE, 16'hFFFF, 1'b1);
        plan_word(CMD_TICK, 16'h5555, 1'b1);
        plan_reg(REG_FILTER_COEF, 1);
        plan_reg(REG_THRESHOLD_CENTER, 32'h0000_7FFF);
        plan_word(CMD_SAMPLE, 16'h7FFF, 1'b1);
        plan_word(CMD_SAMPLE, 16'h8000, 1'b1);
        plan_reg(REG_ZCD_ENABLE, 0);
        plan_word(CMD_SAMPLE, 16'h1234, 1'b1);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (dir_plan[i])
        begin
            if (dir_plan[i].is_reg)
            begin
                settle();
                apb_write(dir_plan[i].idx, dir_plan[i].val);
            end
            else
            begin
                send_word(dir_plan[i].word, dir_plan[i].typed, dir_plan[i].res);
            end
        end
        settings++;

        for (int ph = 0; ph < PHASES; ph++)
        begin
            idle_pct = (ph == 4) ? 0 : 18;
            // long lockouts only in the last two settings
            case (ph)
                0: program_regs(1'b1, 0, -32768, 0, 0, 0, 1'b0, AUX_PLAIN);
                8: program_regs(1'b1, $urandom_range(40), $urandom_range(4000) - 2000,
                                $urandom_range(3000), 65535, $urandom_range(20, 4), 1'b1,
                                AUX_TONE);
                9: program_regs(1'b1, 127, 32767, 16383, 65535, 65535, 1'b1, AUX_SPARE);
                default:
                    program_regs($urandom_range(9) != 0,
                                 ($urandom_range(7) == 0) ? $urandom_range(127, 65)
                                                          : $urandom_range(48),
                                 $urandom_range(4000) - 2000, $urandom_range(3000),
                                 $urandom_range(24),
                                 ($urandom_range(5) == 0) ? $urandom_range(3)
                                                          : $urandom_range(20, 4),
                                 $urandom_range(1), 2'($urandom_range(3)));
            endcase

            amp = $urandom_range(32767, 500);
            hp  = $urandom_range(8, 1);
            run = 0;
            lvl = 1'b0;
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                roll       = $urandom_range(99);
                w.estop_ok = ($urandom_range(4) != 0);
                w.cmd      = CMD_SAMPLE;
                if (roll < 40)
                begin
                    w.cmd    = CMD_TICK;
                    w.sample = 16'($urandom);
                end
                else if (roll < 50)
                begin
                    w.sample = 16'($urandom);
                end
                else
                begin
                    // square wave with jitter, so the comparator keeps crossing
                    if (run <= 0)
                    begin
                        lvl = !lvl;
                        run = $urandom_range(hp, 1);
                        if ($urandom_range(3) == 0)
                            amp = $urandom_range(32767);
                    end
                    run--;
                    s = (lvl ? amp : -amp) + int'($urandom_range(255)) - 128;
                    if (s > 32767)
                        s = 32767;
                    if (s < -32768)
                        s = -32768;
                    w.sample = 16'(s);
                end
                send_word(w, 1'b0, '0);
            end
        end

        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d words over %0d register settings; %0d results checked, %0d pulses.",
                 words_in, settings, checked, pulses);
        if (errors == 0 && pending_results.size() == 0)
            $display("[audio_zero_cross_pulse_trigger] OK");
        else
            $display("[audio_zero_cross_pulse_trigger] ERROR");
        $finish;
    end

endmodule

/* files.f */
design/azct_pkg.sv
design/azct_item_if.sv
design/azct_result_if.sv
design/azct_core.sv
design/audio_zero_cross_pulse_trigger.sv
design/azct_checker.sv
tb/tb_audio_zero_cross_pulse_trigger.sv
